// File: hw/rtl/slst_pkg.sv
// Shared types and constants for the sequential list store.
// Holds the command codes, the cell-row control struct and the sequencer states.
// No dependencies.
package slst_pkg;

  localparam int POS_W         = 8;
  localparam int VAL_W         = 32;
  localparam int CMD_W         = 2;
  localparam int DEF_CAPACITY  = 128;
  localparam int DEF_ELEM_BITS = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_ROTATE,
    RING_INSERT,
    RING_DELETE
  } ring_kind_t;

  typedef struct packed {
    ring_kind_t       kind;
    logic [POS_W-1:0] pos0;
  } ring_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/slst_cell.sv
// One element cell of the list row: holds one entry and takes its next value
// from itself, its left or right neighbor, or the insert value. Uses slst_pkg.
module slst_cell
  import slst_pkg::*;
#(
  parameter int IDX_W     = 7,
  parameter int ELEM_BITS = DEF_ELEM_BITS,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  ring_ctl_t            ctl,
  input  logic [ELEM_BITS-1:0] ins_value,
  input  logic [ELEM_BITS-1:0] left_data,
  input  logic [ELEM_BITS-1:0] right_data,
  output logic [ELEM_BITS-1:0] data_out
);

  localparam int CMP_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

  logic [ELEM_BITS-1:0] data_r;
  logic [ELEM_BITS-1:0] data_nxt;
  logic [CMP_W-1:0]     my_idx;
  logic [CMP_W-1:0]     tgt_idx;

  assign my_idx  = CMP_W'(IDX);
  assign tgt_idx = CMP_W'(ctl.pos0);

  always_comb begin
    case (ctl.kind)
      RING_ROTATE: data_nxt = right_data;
      RING_INSERT: begin
        if (my_idx == tgt_idx) begin
          data_nxt = ins_value;
        end else if (my_idx > tgt_idx) begin
          data_nxt = left_data;
        end else begin
          data_nxt = data_r;
        end
      end
      RING_DELETE: begin
        if (my_idx >= tgt_idx) begin
          data_nxt = right_data;
        end else begin
          data_nxt = data_r;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

// File: hw/rtl/sequential_list_store_core.sv
// Top level of the sequential list store: a row of element cells plus the
// command sequencer and the result register. Uses slst_pkg and slst_cell.
//
// The list lives in a row of CAPACITY cells, one element per cell, with the
// length kept in a counter that reset clears to empty. Insert, delete and any
// rejected command need no rotation: the whole row shifts at once and the
// result is in the output register the cycle after the transaction, so such
// commands can be taken every cycle while results are drained. Get and locate
// rotate the row once around through cell 0, where one comparator looks at
// each element in turn; a valid get or any locate therefore keeps the input
// side busy until that full rotation is done, which also brings every
// element back to its own cell.
module sequential_list_store_core
  import slst_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // position[7:0], item_value[39:8]
  input  logic [1:0]  in_tuser,  // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[0], read_value[32:1], found[33], found_position[41:34],
  // list_length[49:42], zero fill[55:50]
  output logic [55:0] out_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // Input fields
  cmd_t              cmd;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  item_value;
  logic [ELEM_BITS-1:0] in_elem;
  logic [ELEM_BITS+VAL_W-1:0] in_ext;

  assign cmd        = cmd_t'(in_tuser);
  assign position   = in_tdata[POS_W-1:0];
  assign item_value = in_tdata[POS_W+VAL_W-1:POS_W];
  assign in_ext     = {{ELEM_BITS{1'b0}}, item_value};
  assign in_elem    = in_ext[ELEM_BITS-1:0];

  // Control and search state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     k_r;
  logic                 is_get_r;
  logic [POS_W-1:0]     pos0_r;
  logic [ELEM_BITS-1:0] key_r;
  logic                 fnd_r;
  logic [CNT_W-1:0]     fpos_r;
  logic [ELEM_BITS-1:0] rd_r;

  // Output register
  logic             out_valid_r;
  logic             out_status_r;
  logic [VAL_W-1:0] out_read_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_fpos_r;
  logic [POS_W-1:0] out_len_r;

  logic [CMP_W-1:0] pos_c, n_c;
  logic             get_ok, ins_ok, del_ok;
  logic             accept, slot_free, scan_start, load_now, load_scan;
  logic             imm_status;
  ring_ctl_t        ring_ctl;

  logic [ELEM_BITS-1:0] cell_data [CAPACITY];
  logic [ELEM_BITS-1:0] head;
  logic                 get_hit, loc_hit;

  assign pos_c  = CMP_W'(position);
  assign n_c    = CMP_W'(count_r);
  assign get_ok = (position != '0) && (pos_c <= n_c);
  assign del_ok = get_ok;
  assign ins_ok = (position != '0) && (pos_c <= n_c + CMP_W'(1)) &&
                  (n_c < CMP_W'(CAPACITY));

  assign slot_free  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign scan_start = accept && (((cmd == CMD_GET) && get_ok) || (cmd == CMD_LOCATE));
  assign load_now   = accept && !scan_start;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (scan_start) state_nxt = ST_SCAN;
      ST_SCAN: if (k_r == LAST_IDX) state_nxt = ST_DONE;
      ST_DONE: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready     = 1'b0;
    load_scan     = 1'b0;
    ring_ctl.kind = RING_HOLD;
    ring_ctl.pos0 = position - POS_W'(1);
    case (state_r)
      ST_IDLE: begin
        in_tready = slot_free;
        if (accept && (cmd == CMD_INSERT) && ins_ok) ring_ctl.kind = RING_INSERT;
        if (accept && (cmd == CMD_DELETE) && del_ok) ring_ctl.kind = RING_DELETE;
      end
      ST_SCAN: ring_ctl.kind = RING_ROTATE;
      ST_DONE: load_scan = slot_free;
      default: ring_ctl.kind = RING_HOLD;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ring_ctl.kind == RING_INSERT) count_nxt = count_r + CNT_W'(1);
    if (ring_ctl.kind == RING_DELETE) count_nxt = count_r - CNT_W'(1);
  end

  always_comb begin
    case (cmd)
      CMD_INSERT: imm_status = !ins_ok;
      CMD_DELETE: imm_status = !del_ok;
      default:    imm_status = 1'b1;
    endcase
  end

  // Row of element cells; the last cell wraps to cell 0 for rotation.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == CAPACITY - 1) ? 0 : i + 1;
    slst_cell #(
      .IDX_W     (IDX_W),
      .ELEM_BITS (ELEM_BITS),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ring_ctl),
      .ins_value  (in_elem),
      .left_data  (cell_data[L]),
      .right_data (cell_data[R]),
      .data_out   (cell_data[i])
    );
  end

  // During the scan, cell 0 holds the element whose index equals k_r.
  assign head    = cell_data[0];
  assign get_hit = is_get_r && (CMP_W'(k_r) == CMP_W'(pos0_r));
  assign loc_hit = !is_get_r && !fnd_r && (CMP_W'(k_r) < n_c) && (head == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (scan_start) begin
        k_r <= '0;
      end else if (state_r == ST_SCAN) begin
        k_r <= k_r + IDX_W'(1);
      end
      if (load_now || load_scan) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      is_get_r <= (cmd == CMD_GET);
      pos0_r   <= position - POS_W'(1);
      key_r    <= in_elem;
      fnd_r    <= 1'b0;
      fpos_r   <= '0;
      rd_r     <= '0;
    end else if (state_r == ST_SCAN) begin
      if (get_hit) rd_r <= head;
      if (loc_hit) begin
        fnd_r  <= 1'b1;
        fpos_r <= CNT_W'(k_r) + CNT_W'(1);
      end
    end
  end

  logic [CNT_W+POS_W-1:0]     len_ext, fpos_ext;
  logic [ELEM_BITS+VAL_W-1:0] rd_ext;

  assign len_ext  = {{POS_W{1'b0}}, count_nxt};
  assign fpos_ext = {{POS_W{1'b0}}, fpos_r};
  assign rd_ext   = {{VAL_W{1'b0}}, rd_r};

  always_ff @(posedge clk) begin
    if (load_now) begin
      out_status_r <= imm_status;
      out_read_r   <= '0;
      out_found_r  <= 1'b0;
      out_fpos_r   <= '0;
      out_len_r    <= len_ext[POS_W-1:0];
    end else if (load_scan) begin
      out_status_r <= 1'b0;
      out_read_r   <= rd_ext[VAL_W-1:0];
      out_found_r  <= fnd_r;
      out_fpos_r   <= fpos_ext[POS_W-1:0];
      out_len_r    <= len_ext[POS_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_len_r, out_fpos_r, out_found_r, out_read_r, out_status_r};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && (k_r == LAST_IDX) |=> (state_r == ST_DONE))
    else $error("scan did not end after a full rotation");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd == CMD_INSERT) && ins_ok |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("accepted insert did not grow the list");

  a_scan_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(count_r))
    else $error("list length changed during a scan");

  // The search registers are only meaningful once a scan has run.
  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && fnd_r |-> (fpos_r != '0))
    else $error("match flagged without a position");
`endif

endmodule
